// ===== design/mpffl_pkg.sv =====
// ----------------------------------------------------------------------------
// mpffl_pkg
// Types, constants and register codes for the mirrored pin force loop unit.
// ----------------------------------------------------------------------------
package mpffl_pkg;

	// pin array of the left half
	localparam int HALF_COLS = 4;
	localparam int ROW_COUNT = 8;
	localparam int PIN_COUNT = HALF_COLS * ROW_COUNT;
	localparam int IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

	// field widths
	localparam int COL_W    = 2;
	localparam int ROW_W    = 3;
	localparam int FORCE_W  = 12;
	localparam int HEIGHT_W = 10;
	localparam int GAIN_W   = 16;
	localparam int DT_W     = 16;
	localparam int SPEED_W  = 32;
	localparam int NET_W    = 16;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// datapath widths
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 36;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 56;
	localparam int NETQ_W  = 30;
	localparam int HSUM_W  = 36;

	// fixed constants
	localparam logic [FORCE_W-1:0]  FORCE_OFFSET = 12'd30;
	localparam logic [NETQ_W-1:0]   DEADBAND_Q8  = 30'd7680;
	localparam logic [GAIN_W-1:0]   K_KEEP       = 16'd3277;
	localparam logic [GAIN_W-1:0]   K_PUSH       = 16'd62259;
	localparam logic [GAIN_W-1:0]   K_DECAY      = 16'd61604;
	localparam logic [GAIN_W-1:0]   K_BLEND      = 16'd1966;
	localparam logic [GAIN_W-1:0]   ONE_Q8       = 16'd256;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 10'd1023;

	// register reset values
	localparam logic [GAIN_W-1:0]   LEFT_STRENGTH_RST = 16'd256;
	localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 16'd256;
	localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST    = 16'd0;
	localparam logic [HEIGHT_W-1:0] MIN_HEIGHT_RST    = 10'd0;
	localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RST    = 10'd1023;
	localparam logic [HEIGHT_W-1:0] MID_HEIGHT_RST    = 10'd512;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LEFT_STRENGTH = 3'd0,
		REG_PROP_GAIN     = 3'd1,
		REG_DERIV_GAIN    = 3'd2,
		REG_MIN_HEIGHT    = 3'd3,
		REG_MAX_HEIGHT    = 3'd4,
		REG_MID_HEIGHT    = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LF,
		ST_MF,
		ST_NET,
		ST_PD1,
		ST_PD2,
		ST_NV1,
		ST_NV2,
		ST_NVC,
		ST_DEC1,
		ST_DEC2,
		ST_DECC,
		ST_HT1,
		ST_HT2
	} state_t;

	typedef struct packed {
		logic [COL_W-1:0]    pin_col;
		logic [ROW_W-1:0]    pin_row;
		logic [FORCE_W-1:0]  local_force;
		logic [FORCE_W-1:0]  mirror_force;
		logic [HEIGHT_W-1:0] measured_height;
		logic [DT_W-1:0]     time_step;
	} mpffl_in_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] new_height;
		logic [HEIGHT_W-1:0] mirrored_height;
		logic                hit_limit;
	} mpffl_out_t;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed;
		logic [NET_W-1:0]    prior;
		logic [HEIGHT_W-1:0] target;
	} pin_entry_t;

endpackage

// ===== design/mirrored_pin_force_feedback_loop_unit.sv =====
// ----------------------------------------------------------------------------
// mirrored_pin_force_feedback_loop_unit
// Per-pin force feedback update with mirrored height output.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid/in_stall/in_data carries one pin transaction: pin
//  column and row, local and mirror force, measured height and time step.
//  Output channel out_valid/out_stall/out_data returns one transaction per
//  input: new height, mirrored height and the limit flag.
//  cfg_en/cfg_addr/cfg_data write the gain and height registers; write them
//  only while no transaction is in flight.
//  Each transaction is processed from acceptance to result, with extra steps
//  when the velocity smoothing path is taken; a new transaction is accepted
//  only once the sequencer is back in idle. The sequence is set by the single
//  shared 17x36 multiply-accumulate unit that the sequencer steps through the
//  force, PD, velocity and height products, after the registered state read.
//  in_stall is high whenever the sequencer is busy. A finished result sits in
//  the output register; the next transaction is accepted and processed
//  meanwhile, and the sequencer holds in its last step while out_stall keeps
//  the output register full.
//  Reset clears the configuration registers to their defaults and marks all pin state as
//  unwritten, so every pin starts at zero velocity and the reset mid height.
// ----------------------------------------------------------------------------
module mirrored_pin_force_feedback_loop_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mpffl_pkg::mpffl_in_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mpffl_pkg::mpffl_out_t                out_data,
	input  logic                                 cfg_en,
	input  logic [mpffl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mpffl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mpffl_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0]   left_strength_q;
	logic [GAIN_W-1:0]   prop_gain_q;
	logic [GAIN_W-1:0]   deriv_gain_q;
	logic [HEIGHT_W-1:0] min_height_q;
	logic [HEIGHT_W-1:0] max_height_q;
	logic [HEIGHT_W-1:0] mid_height_q;

	// sequencer and datapath registers
	state_t                     state_q, state_d;
	mpffl_in_t                  in_q;
	logic [IDX_W-1:0]           idx_q;
	pin_entry_t                 mem_q [PIN_COUNT];
	logic [PIN_COUNT-1:0]       valid_q;
	pin_entry_t                 rd_q;
	logic                       rd_valid_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [NET_W-1:0]    net_q;
	logic signed [MUL_B_W-1:0]  pd_q;
	logic signed [SPEED_W-1:0]  nv_q;
	logic signed [SPEED_W-1:0]  vn_q;
	logic                       out_valid_q;
	mpffl_out_t                 out_q;

	// combinational
	logic                       accept;
	logic                       fin_fire;
	pin_entry_t                 cur;
	logic signed [SPEED_W-1:0]  v_old;
	logic signed [NET_W-1:0]    prior;
	logic [FORCE_W-1:0]         lf;
	logic [FORCE_W-1:0]         mf;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic                       acc_en;
	logic                       acc_add;
	logic signed [PROD_W-1:0]   prod;
	logic signed [ACC_W-1:0]    acc_d;
	logic [IDX_W-1:0]           idx_d;
	logic signed [NETQ_W-1:0]   net_q8;
	logic [NETQ_W-1:0]          net_mag;
	logic [NETQ_W-1:0]          net_db;
	logic [NETQ_W-9:0]          net_int;
	logic signed [NET_W-1:0]    net_d;
	logic signed [NET_W:0]      net_diff;
	logic signed [SPEED_W-1:0]  acc_sat;
	logic signed [SPEED_W:0]    nv_abs;
	logic                       take_nv;
	logic signed [SPEED_W-1:0]  dtv;
	logic signed [HEIGHT_W:0]   h_diff;
	logic signed [HSUM_W-1:0]   h_sum;
	logic signed [HSUM_W-1:0]   h_full;
	logic [HEIGHT_W-1:0]        h_new;
	logic                       h_hit;
	logic signed [HEIGHT_W+2:0] mir_s;
	logic [HEIGHT_W-1:0]        mir;

	function automatic logic [COL_W-1:0] col_wrap(input logic [COL_W-1:0] c);
		logic [COL_W-1:0] r;
		r = c;
		for (int k = 0; k < (1 << COL_W); k++) begin
			if (int'(r) >= HALF_COLS)
				r = r - COL_W'(HALF_COLS);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W-1:0] c);
		logic [ROW_W-1:0] r;
		r = c;
		for (int k = 0; k < (1 << ROW_W); k++) begin
			if (int'(r) >= ROW_COUNT)
				r = r - ROW_W'(ROW_COUNT);
		end
		return r;
	endfunction

	// floor shift by 16 and saturate to the signed 32-bit range
	function automatic logic signed [SPEED_W-1:0] sat_shift(
		input logic signed [ACC_W-1:0] a);
		logic [ACC_W-17:0] s;
		s = a[ACC_W-1:16];
		if (s[ACC_W-17:SPEED_W-1] == '0 || s[ACC_W-17:SPEED_W-1] == '1)
			return $signed(s[SPEED_W-1:0]);
		else if (s[ACC_W-17])
			return $signed({1'b1, {(SPEED_W-1){1'b0}}});
		else
			return $signed({1'b0, {(SPEED_W-1){1'b1}}});
	endfunction

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fin_fire  = (state_q == ST_HT2) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_strength_q <= LEFT_STRENGTH_RST;
			prop_gain_q     <= PROP_GAIN_RST;
			deriv_gain_q    <= DERIV_GAIN_RST;
			min_height_q    <= MIN_HEIGHT_RST;
			max_height_q    <= MAX_HEIGHT_RST;
			mid_height_q    <= MID_HEIGHT_RST;
		end else if (cfg_en) begin
			case (cfg_addr)
				REG_LEFT_STRENGTH: left_strength_q <= cfg_data[GAIN_W-1:0];
				REG_PROP_GAIN:     prop_gain_q     <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data[GAIN_W-1:0];
				REG_MIN_HEIGHT:    min_height_q    <= cfg_data[HEIGHT_W-1:0];
				REG_MAX_HEIGHT:    max_height_q    <= cfg_data[HEIGHT_W-1:0];
				REG_MID_HEIGHT:    mid_height_q    <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// pin index
	assign idx_d = IDX_W'(int'(col_wrap(in_data.pin_col)) * ROW_COUNT
		+ int'(row_wrap(in_data.pin_row)));

	// current pin state, unwritten pins read as reset values
	always_comb begin
		if (rd_valid_q) begin
			cur = rd_q;
		end else begin
			cur.speed  = '0;
			cur.prior  = '0;
			cur.target = MID_HEIGHT_RST;
		end
	end
	assign v_old = $signed(cur.speed);
	assign prior = $signed(cur.prior);

	assign lf = (in_q.local_force > FORCE_OFFSET) ? in_q.local_force - FORCE_OFFSET : '0;
	assign mf = (in_q.mirror_force > FORCE_OFFSET) ? in_q.mirror_force - FORCE_OFFSET : '0;

	// net force: deadband, truncate toward zero, saturate
	always_comb begin
		net_q8  = acc_q[NETQ_W-1:0];
		net_mag = net_q8[NETQ_W-1] ? NETQ_W'(-net_q8) : NETQ_W'(net_q8);
		net_db  = (net_mag > DEADBAND_Q8) ? net_mag - DEADBAND_Q8 : '0;
		net_int = net_db[NETQ_W-1:8];
		if (net_q8[NETQ_W-1]) begin
			if (net_int > (NETQ_W-8)'(32768))
				net_d = $signed({1'b1, {(NET_W-1){1'b0}}});
			else
				net_d = NET_W'(-$signed({1'b0, net_int}));
		end else begin
			if (net_int > (NETQ_W-8)'(32767))
				net_d = $signed({1'b0, {(NET_W-1){1'b1}}});
			else
				net_d = $signed(net_int[NET_W-1:0]);
		end
	end

	assign net_diff = {net_q[NET_W-1], net_q} - {prior[NET_W-1], prior};
	assign acc_sat  = sat_shift(acc_q);
	assign nv_abs   = nv_q[SPEED_W-1] ? -{nv_q[SPEED_W-1], nv_q} : {nv_q[SPEED_W-1], nv_q};
	assign take_nv  = nv_abs < $signed({v_old[SPEED_W-1], v_old});

	// height update, clamp and mirrored height
	always_comb begin
		dtv    = $signed(acc_q[SPEED_W+15:16]);
		h_diff = $signed({1'b0, in_q.measured_height}) - $signed({1'b0, cur.target});
		h_sum  = ({{(HSUM_W-HEIGHT_W-1){h_diff[HEIGHT_W]}}, h_diff} <<< 8)
			+ ({{(HSUM_W-HEIGHT_W-1){h_diff[HEIGHT_W]}}, h_diff} <<< 7)
			+ $signed({{(HSUM_W-HEIGHT_W-8){1'b0}}, cur.target, 8'd0})
			+ {{(HSUM_W-SPEED_W){dtv[SPEED_W-1]}}, dtv};
		h_full = h_sum >>> 8;
		h_hit  = 1'b0;
		if (h_full < $signed({{(HSUM_W-HEIGHT_W){1'b0}}, min_height_q})) begin
			h_full = $signed({{(HSUM_W-HEIGHT_W){1'b0}}, min_height_q});
			h_hit  = 1'b1;
		end
		if (h_full > $signed({{(HSUM_W-HEIGHT_W){1'b0}}, max_height_q})) begin
			h_full = $signed({{(HSUM_W-HEIGHT_W){1'b0}}, max_height_q});
			h_hit  = 1'b1;
		end
		h_new  = h_full[HEIGHT_W-1:0];
		mir_s = $signed({2'b00, mid_height_q, 1'b0}) - $signed({3'b000, h_new});
		if (mir_s < 0)
			mir = '0;
		else if (mir_s > $signed({3'b000, HEIGHT_MAX}))
			mir = HEIGHT_MAX;
		else
			mir = mir_s[HEIGHT_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_LF;
			ST_LF:   state_d = ST_MF;
			ST_MF:   state_d = ST_NET;
			ST_NET:  state_d = ST_PD1;
			ST_PD1:  state_d = ST_PD2;
			ST_PD2:  state_d = ST_NV1;
			ST_NV1:  state_d = ST_NV2;
			ST_NV2:  state_d = ST_NVC;
			ST_NVC:  state_d = ST_DEC1;
			ST_DEC1: state_d = take_nv ? ST_HT1 : ST_DEC2;
			ST_DEC2: state_d = ST_DECC;
			ST_DECC: state_d = ST_HT1;
			ST_HT1:  state_d = ST_HT2;
			ST_HT2:  if (fin_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// shared multiplier operands per step
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		acc_en  = 1'b0;
		acc_add = 1'b0;
		case (state_q)
			ST_LF: begin
				mul_a  = $signed({1'b0, left_strength_q});
				mul_b  = $signed({{(MUL_B_W-FORCE_W){1'b0}}, lf});
				acc_en = 1'b1;
			end
			ST_MF: begin
				mul_a   = $signed({1'b0, ONE_Q8});
				mul_b   = -$signed({{(MUL_B_W-FORCE_W){1'b0}}, mf});
				acc_en  = 1'b1;
				acc_add = 1'b1;
			end
			ST_PD1: begin
				mul_a  = $signed({1'b0, prop_gain_q});
				mul_b  = {{(MUL_B_W-NET_W){net_q[NET_W-1]}}, net_q};
				acc_en = 1'b1;
			end
			ST_PD2: begin
				mul_a   = $signed({1'b0, deriv_gain_q});
				mul_b   = {{(MUL_B_W-NET_W-1){net_diff[NET_W]}}, net_diff};
				acc_en  = 1'b1;
				acc_add = 1'b1;
			end
			ST_NV1: begin
				mul_a  = $signed({1'b0, K_KEEP});
				mul_b  = {{(MUL_B_W-SPEED_W){v_old[SPEED_W-1]}}, v_old};
				acc_en = 1'b1;
			end
			ST_NV2: begin
				mul_a   = $signed({1'b0, K_PUSH});
				mul_b   = -pd_q;
				acc_en  = 1'b1;
				acc_add = 1'b1;
			end
			ST_DEC1: begin
				mul_a  = $signed({1'b0, K_DECAY});
				mul_b  = {{(MUL_B_W-SPEED_W){v_old[SPEED_W-1]}}, v_old};
				acc_en = 1'b1;
			end
			ST_DEC2: begin
				mul_a   = $signed({1'b0, K_BLEND});
				mul_b   = {{(MUL_B_W-SPEED_W){nv_q[SPEED_W-1]}}, nv_q};
				acc_en  = 1'b1;
				acc_add = 1'b1;
			end
			ST_HT1: begin
				mul_a  = $signed({1'b0, in_q.time_step});
				mul_b  = {{(MUL_B_W-SPEED_W){vn_q[SPEED_W-1]}}, vn_q};
				acc_en = 1'b1;
			end
			default: ;
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign acc_d = acc_add ? acc_q + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod}
		: {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_fire)
				valid_q[idx_q] <= 1'b1;
			if (fin_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q  <= in_data;
			idx_q <= idx_d;
		end
		if (state_q == ST_READ) begin
			rd_q       <= mem_q[idx_q];
			rd_valid_q <= valid_q[idx_q];
		end
		if (acc_en)
			acc_q <= acc_d;
		if (state_q == ST_NET)
			net_q <= net_d;
		if (state_q == ST_NV1)
			pd_q <= acc_q[MUL_B_W-1:0];
		if (state_q == ST_NVC)
			nv_q <= acc_sat;
		if (state_q == ST_DEC1 && take_nv)
			vn_q <= nv_q;
		if (state_q == ST_DECC)
			vn_q <= acc_sat;
		if (fin_fire) begin
			mem_q[idx_q] <= '{speed: h_hit ? '0 : vn_q, prior: net_q, target: h_new};
			out_q        <= '{new_height: h_new, mirrored_height: mir, hit_limit: h_hit};
		end
	end

endmodule
